// ===== hw/rtl/marked_frame_receiver_top_macros.svh =====
// Assertion helpers used by the receiver deframer.
`ifndef MARKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define MARKED_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define MFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MFR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define MFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mfr_pkg.sv =====
package mfr_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 9;
   localparam int KIND_W  = 3;
   localparam int INDEX_W = 2;

   localparam logic [BYTE_W-1:0]  START_MARK_RESET = 8'd170;
   localparam logic [BYTE_W-1:0]  END_MARK_RESET   = 8'd85;
   localparam logic [COUNT_W-1:0] MAX_BYTES_RESET  = 9'd64;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD  = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_CHECKSUM = 3'd2,
      KIND_NO_END   = 3'd3,
      KIND_OVERFLOW = 3'd4
   } mfr_kind_type;

   typedef enum logic [INDEX_W-1:0] {
      CSR_START_MARK = 2'd0,
      CSR_END_MARK   = 2'd1,
      CSR_MAX_BYTES  = 2'd2
   } mfr_csr_index_type;

   typedef enum logic [5:0] {
      PH_HUNT = 6'b000001,
      PH_CMD  = 6'b000010,
      PH_LEN  = 6'b000100,
      PH_PAY  = 6'b001000,
      PH_CHK  = 6'b010000,
      PH_ENDM = 6'b100000
   } mfr_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  start_mark;
      logic [BYTE_W-1:0]  end_mark;
      logic [COUNT_W-1:0] max_frame_bytes;
   } mfr_cfg_type;

   typedef struct packed {
      logic              fire;
      logic [BYTE_W-1:0] rx_byte;
   } mfr_step_type;

   typedef struct packed {
      logic              valid;
      mfr_kind_type      kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] payload_index;
      logic [BYTE_W-1:0] command_id;
      logic [BYTE_W-1:0] payload_length;
      logic              frame_done;
   } mfr_result_type;

endpackage

// ===== hw/rtl/mfr_if.sv =====
interface mfr_req_if import mfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfr_rsp_if import mfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [BYTE_W-1:0] payload_byte;
   logic [BYTE_W-1:0] payload_index;
   logic [BYTE_W-1:0] command_id;
   logic [BYTE_W-1:0] payload_length;
   logic              frame_done;
   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output command_id, output payload_length,
                   output frame_done, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input payload_index, input command_id, input payload_length,
                 input frame_done, output ready);
endinterface

interface mfr_csr_if import mfr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [COUNT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mfr_csr_regs.sv =====
module mfr_csr_regs import mfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mfr_csr_if.sink     csr,
   output mfr_cfg_type cfg
);

   mfr_cfg_type cfg_ff;
   mfr_cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_START_MARK: cfg_in.start_mark      = csr.data[BYTE_W-1:0];
            CSR_END_MARK:   cfg_in.end_mark        = csr.data[BYTE_W-1:0];
            CSR_MAX_BYTES:  cfg_in.max_frame_bytes = csr.data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_mark      <= START_MARK_RESET;
         cfg_ff.end_mark        <= END_MARK_RESET;
         cfg_ff.max_frame_bytes <= MAX_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/mfr_in_stage.sv =====
module mfr_in_stage import mfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mfr_req_if.sink      req,
   input  logic         out_free,
   output mfr_step_type step
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              take;

   // Hand the held byte on whenever the result register has room.
   assign step.fire    = in_valid_ff && out_free;
   assign step.rx_byte = in_byte_ff;
   assign req.ready    = !in_valid_ff || step.fire;
   assign take         = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (step.fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req.rx_byte;
      end
   end

endmodule

// ===== hw/rtl/mfr_deframer.sv =====
`include "marked_frame_receiver_top_macros.svh"

module mfr_deframer import mfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  mfr_cfg_type    cfg,
   input  mfr_step_type   step,
   output mfr_result_type result
);

   mfr_phase_type      phase_ff, phase_in;
   logic [BYTE_W-1:0]  command_ff, command_in;
   logic [BYTE_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  checksum_ff, checksum_in;
   logic [COUNT_W-1:0] frame_count_ff, frame_count_in;

   logic              in_frame;
   logic              have;
   logic              done;
   logic              no_end;
   mfr_kind_type      kind;
   logic [BYTE_W-1:0] pbyte;
   logic [BYTE_W-1:0] pidx;
   logic [BYTE_W-1:0] b;

   assign b = step.rx_byte;

   always_comb begin
      phase_in       = phase_ff;
      command_in     = command_ff;
      length_in      = length_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      checksum_in    = checksum_ff;
      frame_count_in = frame_count_ff;
      in_frame       = 1'b0;
      have           = 1'b0;
      done           = 1'b0;
      no_end         = 1'b0;
      kind           = KIND_PAYLOAD;
      pbyte          = '0;
      pidx           = '0;

      case (phase_ff)
         PH_HUNT: begin
            if (b == cfg.start_mark) begin
               command_in     = '0;
               length_in      = '0;
               count_in       = '0;
               sum_in         = '0;
               checksum_in    = '0;
               frame_count_in = COUNT_W'(1);
               phase_in       = PH_CMD;
               in_frame       = 1'b1;
            end
         end
         PH_CMD: begin
            command_in     = b;
            sum_in         = b;
            frame_count_in = frame_count_ff + 1'b1;
            phase_in       = PH_LEN;
            in_frame       = 1'b1;
         end
         PH_LEN: begin
            length_in      = b;
            sum_in         = sum_ff + b;
            count_in       = '0;
            frame_count_in = frame_count_ff + 1'b1;
            phase_in       = (b != '0) ? PH_PAY : PH_CHK;
            in_frame       = 1'b1;
         end
         PH_PAY: begin
            have           = 1'b1;
            pbyte          = b;
            pidx           = count_ff;
            sum_in         = sum_ff + b;
            count_in       = count_ff + 1'b1;
            frame_count_in = frame_count_ff + 1'b1;
            if (count_in >= length_ff) begin
               phase_in = PH_CHK;
            end
            in_frame       = 1'b1;
         end
         PH_CHK: begin
            checksum_in    = b;
            frame_count_in = frame_count_ff + 1'b1;
            phase_in       = PH_ENDM;
            in_frame       = 1'b1;
         end
         PH_ENDM: begin
            phase_in = PH_HUNT;
            if (b != cfg.end_mark) begin
               // Drop the frame; this byte is not a start candidate.
               frame_count_in = '0;
               no_end         = 1'b1;
            end else begin
               frame_count_in = frame_count_ff + 1'b1;
               have           = 1'b1;
               done           = 1'b1;
               kind           = (sum_ff == checksum_ff) ? KIND_GOOD : KIND_CHECKSUM;
               in_frame       = 1'b1;
            end
         end
         default: begin
            phase_in       = PH_HUNT;
            frame_count_in = '0;
         end
      endcase

      result.valid          = 1'b0;
      result.kind           = kind;
      result.payload_byte   = pbyte;
      result.payload_index  = pidx;
      result.command_id     = command_in;
      result.payload_length = length_in;
      result.frame_done     = done;

      if (no_end) begin
         result.valid      = 1'b1;
         result.kind       = KIND_NO_END;
         result.frame_done = 1'b1;
      end else if (in_frame && frame_count_in >= cfg.max_frame_bytes) begin
         // Overflow overrides whatever this byte would have reported.
         phase_in              = PH_HUNT;
         frame_count_in        = '0;
         result.valid          = 1'b1;
         result.kind           = KIND_OVERFLOW;
         result.payload_byte   = '0;
         result.payload_index  = '0;
         result.frame_done     = 1'b1;
      end else if (in_frame) begin
         if (done) begin
            frame_count_in = '0;
         end
         result.valid = have;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         command_ff     <= '0;
         length_ff      <= '0;
         count_ff       <= '0;
         sum_ff         <= '0;
         checksum_ff    <= '0;
         frame_count_ff <= '0;
      end else if (step.fire) begin
         phase_ff       <= phase_in;
         command_ff     <= command_in;
         length_ff      <= length_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         checksum_ff    <= checksum_in;
         frame_count_ff <= frame_count_in;
      end
   end

   `MFR_ASSERT_NEXT(a_done_to_hunt, clock, reset, step.fire && result.valid && result.frame_done, phase_ff == PH_HUNT, "closing result did not return to hunting")
   `MFR_ASSERT_NOW(a_pay_count, clock, reset, phase_ff == PH_PAY, count_ff < length_ff, "payload count reached declared length in payload phase")
   `MFR_ASSERT_NOW(a_hunt_count, clock, reset, phase_ff == PH_HUNT, frame_count_ff == '0, "frame byte count not cleared while hunting")

endmodule

// ===== hw/rtl/mfr_out_stage.sv =====
module mfr_out_stage import mfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_fire,
   input  mfr_result_type result,
   output logic           out_free,
   mfr_rsp_if.source      rsp
);

   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   mfr_result_type rsp_data_ff;
   logic           load;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign load     = step_fire && result.valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_kind    = rsp_data_ff.kind;
   assign rsp.payload_byte   = rsp_data_ff.payload_byte;
   assign rsp.payload_index  = rsp_data_ff.payload_index;
   assign rsp.command_id     = rsp_data_ff.command_id;
   assign rsp.payload_length = rsp_data_ff.payload_length;
   assign rsp.frame_done     = rsp_data_ff.frame_done;

endmodule

// ===== hw/rtl/marked_frame_receiver_top.sv =====
// Marked frame receiver: takes one received byte per item on req, hunts for the
// start mark, then reads command, length, that many payload bytes, a checksum
// byte (sum of command, length and payload, mod 256) and the end mark. Each
// payload byte comes out on rsp as a payload item with its index; the frame
// closes with one status item (good, checksum error, end mark missing or
// overflow). A frame whose byte count reaches max_frame_bytes aborts as
// overflow. The block takes one byte per cycle sustained while rsp takes its
// items; a byte is held in the input register, then goes through the phase
// logic into the result register, and a full result register stalls req.
// Write csr only while no byte is in flight.
module marked_frame_receiver_top import mfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mfr_req_if.sink   req,
   mfr_rsp_if.source rsp,
   mfr_csr_if.sink   csr
);

   mfr_cfg_type    cfg;
   mfr_step_type   step;
   mfr_result_type result;
   logic           out_free;

   // Hold the configuration registers.
   mfr_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // Register the incoming byte; advance it when the result side has room.
   mfr_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .out_free (out_free),
      .step     (step)
   );

   // Advance the frame phase and build this byte's result.
   mfr_deframer u_deframer (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .result (result)
   );

   // Hold the result item until rsp takes it.
   mfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step.fire),
      .result    (result),
      .out_free  (out_free),
      .rsp       (rsp)
   );

endmodule
